### design/tkh_pkg.sv
// Shared constants, types and helper functions for the triple-key hash block.
package tkh_pkg;

   localparam int unsigned LANES      = 4;
   localparam int unsigned MIX_STAGES = 10;
   localparam int unsigned DIV_CELLS  = 64;

   localparam logic [63:0] HP1     = 64'd2654435761;
   localparam logic [63:0] HP2     = 64'd2246822519;
   localparam logic [63:0] HP3     = 64'd3266489917;
   localparam logic [63:0] HP4     = 64'd668265263;
   localparam logic [63:0] HP5     = 64'h0000_0000_1656_67b1;
   localparam logic [63:0] KEY_LEN = 64'd24;

   localparam logic [63:0] SEED1 = HP5;
   localparam logic [63:0] SEED2 = 64'(SEED1 * HP2 + KEY_LEN);
   localparam logic [63:0] SEED3 = 64'(SEED2 * HP3);
   localparam logic [63:0] SEED4 = 64'(SEED3 * HP4);
   localparam logic [63:0] H_ADD = 64'((HP4 + KEY_LEN) * HP1);

   localparam logic [63:0] SEEDS [LANES] = '{SEED1, SEED2, SEED3, SEED4};
   localparam int unsigned ROT_A [LANES] = '{13, 11, 17, 19};
   localparam int unsigned ROT_B [LANES] = '{17, 19, 13, 11};
   localparam int unsigned ROT_C [LANES] = '{11, 17, 19, 13};

   localparam logic REG_BUCKET_COUNT = 1'b0;

   typedef struct packed {
      logic        valid;
      logic [63:0] hash;
   } hash_xfer_type;

   typedef struct packed {
      logic        valid;
      logic [62:0] rem;
      logic [63:0] dvd;
   } cell_xfer_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] mul_lo(input logic [63:0] x, input logic [63:0] c);
      return 64'(x[31:0]) * 64'(c[31:0]);
   endfunction

   function automatic logic [31:0] mul_hi(input logic [63:0] x, input logic [63:0] c);
      return 32'(x[63:32] * c[31:0]);
   endfunction

   function automatic logic [63:0] mul_join(input logic [63:0] lo, input logic [31:0] hi);
      return lo + {hi, 32'd0};
   endfunction

endpackage

### design/tkh_mix.sv
// Ten-stage hash pipeline: four lanes absorb keys, merge and avalanche.
module tkh_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic signed [7:0]      type_byte,
   input  logic signed [63:0]     key_a,
   input  logic signed [63:0]     key_b,
   input  logic signed [63:0]     key_c,
   output tkh_pkg::hash_xfer_type hash_out
);

   logic [tkh_pkg::MIX_STAGES-1:0] v_ff;
   logic [63:0] kin [tkh_pkg::LANES];
   logic [63:0] k1_ff [3];
   logic [63:0] k2_ff [3];
   logic [63:0] s1_ff [tkh_pkg::LANES];
   logic [63:0] p2lo_ff [tkh_pkg::LANES];
   logic [31:0] p2hi_ff [tkh_pkg::LANES];
   logic [63:0] s3_ff [tkh_pkg::LANES];
   logic [63:0] p4lo_ff [tkh_pkg::LANES];
   logic [31:0] p4hi_ff [tkh_pkg::LANES];
   logic [63:0] s5_ff [tkh_pkg::LANES];
   logic [63:0] p6lo_ff [tkh_pkg::LANES];
   logic [31:0] p6hi_ff [tkh_pkg::LANES];
   logic [63:0] s7_ff [tkh_pkg::LANES];
   logic [63:0] h8_in, h8_ff, p9lo_ff, h10_in, h10_ff;
   logic [31:0] p9hi_ff;
   logic [63:0] ha, hb, hc;

   assign kin[0] = key_a;
   assign kin[1] = key_b;
   assign kin[2] = key_c;
   assign kin[3] = {{56{type_byte[7]}}, type_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[tkh_pkg::MIX_STAGES-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         k1_ff[i] <= kin[i];
         k2_ff[i] <= k1_ff[i];
      end
   end

   for (genvar l = 0; l < tkh_pkg::LANES; l++) begin : g_lane
      logic [63:0] st0, a1_in, m3_add, m3_in, m5, m5_in;

      assign st0    = tkh_pkg::rotl(tkh_pkg::SEEDS[l], tkh_pkg::ROT_A[l]) + kin[l];
      assign a1_in  = st0 + tkh_pkg::rotl(st0, tkh_pkg::ROT_B[l]);
      assign m3_add = (l < 3) ? k2_ff[(l < 3) ? l : 0] : tkh_pkg::HP5;
      assign m3_in  = tkh_pkg::mul_join(p2lo_ff[l], p2hi_ff[l]) + m3_add;
      assign m5     = tkh_pkg::mul_join(p4lo_ff[l], p4hi_ff[l]);
      assign m5_in  = m5 + tkh_pkg::rotl(m5, tkh_pkg::ROT_C[l]);

      always_ff @(posedge clock) begin
         s1_ff[l]   <= a1_in;
         p2lo_ff[l] <= tkh_pkg::mul_lo(s1_ff[l], tkh_pkg::HP1);
         p2hi_ff[l] <= tkh_pkg::mul_hi(s1_ff[l], tkh_pkg::HP1);
         s3_ff[l]   <= m3_in;
         p4lo_ff[l] <= tkh_pkg::mul_lo(s3_ff[l], tkh_pkg::HP2);
         p4hi_ff[l] <= tkh_pkg::mul_hi(s3_ff[l], tkh_pkg::HP2);
         s5_ff[l]   <= m5_in;
         p6lo_ff[l] <= tkh_pkg::mul_lo(s5_ff[l], tkh_pkg::HP3);
         p6hi_ff[l] <= tkh_pkg::mul_hi(s5_ff[l], tkh_pkg::HP3);
         s7_ff[l]   <= tkh_pkg::mul_join(p6lo_ff[l], p6hi_ff[l]);
      end
   end

   always_comb begin
      ha = s7_ff[0] + tkh_pkg::rotl(s7_ff[1], 3) + tkh_pkg::rotl(s7_ff[2], 6)
           + tkh_pkg::rotl(s7_ff[3], 9);
      hb = (ha ^ (ha >> 11)) + tkh_pkg::H_ADD;
      h8_in = hb ^ (hb >> 15);
      hc = tkh_pkg::mul_join(p9lo_ff, p9hi_ff);
      h10_in = hc ^ (hc >> 13);
   end

   always_ff @(posedge clock) begin
      h8_ff   <= h8_in;
      p9lo_ff <= tkh_pkg::mul_lo(h8_ff, tkh_pkg::HP2);
      p9hi_ff <= tkh_pkg::mul_hi(h8_ff, tkh_pkg::HP2);
      h10_ff  <= h10_in;
   end

   assign hash_out.valid = v_ff[tkh_pkg::MIX_STAGES-1];
   assign hash_out.hash  = h10_ff;

endmodule

### design/tkh_div_cell.sv
// One restoring-division cell: takes one dividend bit into the remainder.
module tkh_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [62:0]            divisor,
   input  tkh_pkg::cell_xfer_type cell_in,
   output tkh_pkg::cell_xfer_type cell_out
);

   tkh_pkg::cell_xfer_type cell_ff, cell_nx_in;
   logic [63:0] trial;
   logic        fits;

   always_comb begin
      trial = {cell_in.rem, cell_in.dvd[63]};
      fits  = trial >= {1'b0, divisor};
      cell_nx_in.valid = cell_in.valid;
      cell_nx_in.rem   = fits ? 63'(trial - {1'b0, divisor}) : trial[62:0];
      cell_nx_in.dvd   = {cell_in.dvd[62:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_nx_in.valid;
      end
      cell_ff.rem <= cell_nx_in.rem;
      cell_ff.dvd <= cell_nx_in.dvd;
   end

   assign cell_out = cell_ff;

endmodule

### design/tkh_div.sv
// Chain of division cells: one dividend bit per cell, one hash per cycle.
module tkh_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [62:0]            divisor,
   input  tkh_pkg::hash_xfer_type hash_in,
   output tkh_pkg::cell_xfer_type rem_out
);

   tkh_pkg::cell_xfer_type link [tkh_pkg::DIV_CELLS+1];

   assign link[0].valid = hash_in.valid;
   assign link[0].rem   = '0;
   assign link[0].dvd   = hash_in.hash;

   for (genvar i = 0; i < tkh_pkg::DIV_CELLS; i++) begin : g_cell
      tkh_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .divisor  (divisor),
         .cell_in  (link[i]),
         .cell_out (link[i+1])
      );
   end

   assign rem_out = link[tkh_pkg::DIV_CELLS];

endmodule

### design/triple_key_hash_to_bucket.sv
// Top level: triple-key hash to bucket index with APB bucket-count register.
// The request passes through 10 hash stages, 64 division cells and one output
// register before the result strobe rises. Throughput: one transaction per
// cycle; busy stays low. Reset (synchronous) clears all valid flags and sets
// the bucket count to 1. The receiver cannot stall.
module triple_key_hash_to_bucket (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [7:0]  req_type_byte,
   input  logic signed [63:0] req_key_a,
   input  logic signed [63:0] req_key_b,
   input  logic signed [63:0] req_key_c,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_bucket_index,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   logic [62:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] index_ff, index_in;
   tkh_pkg::hash_xfer_type hash_x;
   tkh_pkg::cell_xfer_type rem_x;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && paddr[3] == tkh_pkg::REG_BUCKET_COUNT) begin
         count_in = pwdata[62:0];
      end
      prdata = (paddr[3] == tkh_pkg::REG_BUCKET_COUNT) ? {1'b0, count_ff} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 63'd1;
      end else begin
         count_ff <= count_in;
      end
   end

   tkh_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .type_byte (req_type_byte),
      .key_a     (req_key_a),
      .key_b     (req_key_b),
      .key_c     (req_key_c),
      .hash_out  (hash_x)
   );

   tkh_div u_div (
      .clock   (clock),
      .reset   (reset),
      .divisor (count_ff),
      .hash_in (hash_x),
      .rem_out (rem_x)
   );

   assign rsp_valid_in = rem_x.valid;
   assign index_in     = (count_ff == '0) ? '1 : {1'b0, rem_x.rem};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      index_ff <= index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = index_ff;

endmodule

### design/tkh_checker.sv
// Port-level checker for the triple-key hash block, bound to the top level.
module tkh_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [63:0] rsp_bucket_index,
   input logic               pready
);

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 75))
      else $error("result without a transaction");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bucket_index == -64'sd1) || !rsp_bucket_index[63])
      else $error("negative bucket index other than error code");

endmodule

bind triple_key_hash_to_bucket tkh_checker u_tkh_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_bucket_index (rsp_bucket_index),
   .pready           (pready)
);
